### sv/bmpd_pkg.sv
// ----------------------------------------------------------------------------
// bmpd_pkg: shared definitions for the mask pack / decimate block
// Widths, register indexes, mode codes, result type and the pair-halving
// function used in decimate mode.
// ----------------------------------------------------------------------------
package bmpd_pkg;

  // Default row limit, in pixels or bytes
  localparam int unsigned MAX_LINE_DEF = 8192;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned LL_W       = 14;

  localparam logic [CFG_IDX_W-1:0] REG_MODE        = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'd1;

  // Operating modes
  localparam logic MODE_PACK     = 1'b0;
  localparam logic MODE_DECIMATE = 1'b1;

  localparam logic [7:0] MSB_BIT = 8'h80;

  // One result from the datapath
  typedef struct packed {
    logic       emit;
    logic [7:0] mask_out;
    logic       row_end;
  } res_t;

  // Keep bits 7,5,3,1 of a, then of b
  function automatic logic [7:0] halve_pair(input logic [7:0] a, input logic [7:0] b);
    halve_pair = {a[7], a[5], a[3], a[1], b[7], b[5], b[3], b[1]};
  endfunction

endpackage

### sv/bmpd_if.sv
// ----------------------------------------------------------------------------
// bmpd_if: channel interfaces
// Input item channel, result channel and configuration write channel,
// each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmpd_in_if;
  logic       valid;
  logic       ready;
  logic       pixel_null;
  logic [7:0] mask_byte;

  modport source (output valid, output pixel_null, output mask_byte, input ready);
  modport sink   (input valid, input pixel_null, input mask_byte, output ready);
endinterface

interface bmpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] mask_out;
  logic       row_end;

  modport source (output valid, output mask_out, output row_end, input ready);
  modport sink   (input valid, input mask_out, input row_end, output ready);
endinterface

interface bmpd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [bmpd_pkg::CFG_IDX_W-1:0]      index;
  logic [bmpd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### sv/bmpd_cfg_regs.sv
// ----------------------------------------------------------------------------
// bmpd_cfg_regs: configuration registers
// Holds the mode and the row length; the length is clamped to 1..MAX_LINE
// when written so the datapath sees a ready-to-use value.
// ----------------------------------------------------------------------------
module bmpd_cfg_regs #(
  parameter int unsigned MAX_LINE = bmpd_pkg::MAX_LINE_DEF
) (
  input  logic          clk,
  input  logic          rst,
  bmpd_cfg_if.sink      cfg_ch,
  output logic          mode,
  output logic [(($clog2(MAX_LINE) + 1) > bmpd_pkg::LL_W ?
                 ($clog2(MAX_LINE) + 1) : bmpd_pkg::LL_W) - 1:0] len
);

  localparam int unsigned CW   = $clog2(MAX_LINE);
  localparam int unsigned CMPW = (CW + 1) > bmpd_pkg::LL_W ? (CW + 1) : bmpd_pkg::LL_W;

  logic [bmpd_pkg::LL_W-1:0] ll;
  logic [CMPW-1:0]           ll_ext;
  logic [CMPW-1:0]           len_next;
  logic                      wr;

  assign cfg_ch.ready = 1'b1;
  assign wr           = cfg_ch.valid && cfg_ch.ready;

  // Clamp the written length
  assign ll     = cfg_ch.data[bmpd_pkg::LL_W-1:0];
  assign ll_ext = CMPW'(ll);

  always_comb begin
    if (ll_ext == '0) begin
      len_next = CMPW'(1);
    end else if (ll_ext > CMPW'(MAX_LINE)) begin
      len_next = CMPW'(MAX_LINE);
    end else begin
      len_next = ll_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= bmpd_pkg::MODE_PACK;
      len  <= CMPW'(1);
    end else if (wr) begin
      unique case (cfg_ch.index)
        bmpd_pkg::REG_MODE:        mode <= cfg_ch.data[0];
        bmpd_pkg::REG_LINE_LENGTH: len  <= len_next;
        default:                   ;
      endcase
    end
  end

endmodule

### sv/bmpd_core.sv
// ----------------------------------------------------------------------------
// bmpd_core: row state and per-item datapath
// Keeps the column count, partial mask byte, row parity and held byte, and
// computes the result for the item presented when fire is high.
// ----------------------------------------------------------------------------
module bmpd_core #(
  parameter int unsigned MAX_LINE = bmpd_pkg::MAX_LINE_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic                 pixel_null,
  input  logic [7:0]           mask_byte,
  input  logic                 mode,
  input  logic [(($clog2(MAX_LINE) + 1) > bmpd_pkg::LL_W ?
                 ($clog2(MAX_LINE) + 1) : bmpd_pkg::LL_W) - 1:0] len,
  output bmpd_pkg::res_t       res
);

  localparam int unsigned CW   = $clog2(MAX_LINE);
  localparam int unsigned CMPW = (CW + 1) > bmpd_pkg::LL_W ? (CW + 1) : bmpd_pkg::LL_W;

  logic [CW-1:0] col, col_next;
  logic [7:0]    acc, acc_next;
  logic          odd, odd_next;
  logic [7:0]    held, held_next;

  logic          last;
  logic [2:0]    pos;
  logic [7:0]    acc_set;

  // Row end when the next column reaches the length
  assign last = (CMPW'(col) + CMPW'(1)) >= len;
  assign pos  = col[2:0];

  assign acc_set = pixel_null ? acc : (acc | (bmpd_pkg::MSB_BIT >> pos));

  // Per-item result and next state
  always_comb begin
    res       = '0;
    acc_next  = acc;
    odd_next  = odd;
    held_next = held;
    col_next  = last ? '0 : col + CW'(1);
    if (mode == bmpd_pkg::MODE_PACK) begin
      acc_next = acc_set;
      if (pos == 3'd7 || last) begin
        res.emit     = 1'b1;
        res.mask_out = acc_set;
        res.row_end  = last;
        acc_next     = '0;
      end
    end else begin
      if (!odd) begin
        if (!col[0]) begin
          held_next = mask_byte;
          if (last) begin
            res.emit     = 1'b1;
            res.mask_out = bmpd_pkg::halve_pair(mask_byte, 8'h00);
            res.row_end  = 1'b1;
          end
        end else begin
          res.emit     = 1'b1;
          res.mask_out = bmpd_pkg::halve_pair(held, mask_byte);
          res.row_end  = last;
        end
      end
      if (last) begin
        odd_next = ~odd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      acc  <= '0;
      odd  <= 1'b0;
      held <= '0;
    end else if (fire) begin
      col  <= col_next;
      acc  <= acc_next;
      odd  <= odd_next;
      held <= held_next;
    end
  end

`ifndef SYNTHESIS
  // A row end restarts the column count
  a_row_end_clears_col: assert property (@(posedge clk) disable iff (rst)
    fire && res.emit && res.row_end |=> col == '0)
    else $error("column count not cleared after row end");

  // Odd rows in decimate mode produce nothing
  a_odd_row_silent: assert property (@(posedge clk) disable iff (rst)
    fire && mode == bmpd_pkg::MODE_DECIMATE && odd |-> !res.emit)
    else $error("result emitted on odd decimate row");

  // Emitting a packed byte empties the accumulator
  a_pack_emit_clears_acc: assert property (@(posedge clk) disable iff (rst)
    fire && mode == bmpd_pkg::MODE_PACK && res.emit |=> acc == '0)
    else $error("accumulator not cleared after pack emit");

  // Column count stays below MAX_LINE
  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    CMPW'(col) < CMPW'(MAX_LINE))
    else $error("column count out of range");
`endif

endmodule

### sv/bit_mask_pack_and_decimate.sv
// ----------------------------------------------------------------------------
// bit_mask_pack_and_decimate: null-mask packer and 2:1 mask decimator
// Input register, row datapath and output register around the config port.
// ----------------------------------------------------------------------------
// The block accepts one item per clock cycle and holds that rate while the
// result side keeps taking items. An accepted item is held in the input
// register; its result is computed from there by the row datapath and
// loaded into the output register, from which it is offered on out_ch.
// in_ch.ready drops only when the output register holds a result that is not
// taken and the input register is also full. In pack mode (mode = 0) each
// item is a pixel null flag and a mask byte comes out every 8 pixels and at
// row end; in decimate mode (mode = 1) each item is a mask byte, pairs on
// even rows give one byte, as does an unpaired last byte, odd rows give none.
// Write configuration only while the block is idle.
module bit_mask_pack_and_decimate #(
  parameter int unsigned MAX_LINE = bmpd_pkg::MAX_LINE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  bmpd_in_if.sink     in_ch,
  bmpd_out_if.source  out_ch,
  bmpd_cfg_if.sink    cfg_ch
);

  localparam int unsigned CW   = $clog2(MAX_LINE);
  localparam int unsigned CMPW = (CW + 1) > bmpd_pkg::LL_W ? (CW + 1) : bmpd_pkg::LL_W;

  logic            mode;
  logic [CMPW-1:0] len;

  logic            s1_valid;
  logic            s1_null;
  logic [7:0]      s1_byte;
  logic            s2_ready;
  logic            fire;
  bmpd_pkg::res_t  res;

  logic            o_valid;
  logic [7:0]      o_mask;
  logic            o_end;

  bmpd_cfg_regs #(.MAX_LINE(MAX_LINE)) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .mode   (mode),
    .len    (len)
  );

  // Handshake through the two register stages
  assign s2_ready     = !o_valid || out_ch.ready;
  assign fire         = s1_valid && s2_ready;
  assign in_ch.ready  = !s1_valid || s2_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_null <= in_ch.pixel_null;
      s1_byte <= in_ch.mask_byte;
    end
  end

  bmpd_core #(.MAX_LINE(MAX_LINE)) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .pixel_null (s1_null),
    .mask_byte  (s1_byte),
    .mode       (mode),
    .len        (len),
    .res        (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s2_ready) begin
      o_valid <= fire && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.emit) begin
      o_mask <= res.mask_out;
      o_end  <= res.row_end;
    end
  end

  assign out_ch.valid    = o_valid;
  assign out_ch.mask_out = o_mask;
  assign out_ch.row_end  = o_end;

endmodule
